// ===== design/rthi_pkg.sv =====
// Shared types, constants and the divider step for the RGB to HSV converter.
package rthi_pkg;

  // Hue sector offsets and scale factors
  localparam logic [7:0] HueRed    = 8'd0;
  localparam logic [7:0] HueGreen  = 8'd85;
  localparam logic [7:0] HueBlue   = 8'd171;
  localparam logic [7:0] HueStep   = 8'd43;
  localparam logic [7:0] FullScale = 8'd255;

  // Queue between the classifier and the divider pipeline
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  // One quotient bit per pipeline stage, quotients always fit 8 bits
  localparam int DivSteps = 8;

  // Classified pixel, as it waits in the queue
  typedef struct packed {
    logic [7:0] value;   // max channel
    logic [7:0] chroma;  // max - min
    logic [7:0] dmag;    // |p - q| of the two other channels
    logic       neg;     // p < q, offset is subtracted
    logic [7:0] offset;  // sector offset
  } cls_t;

  // Queue status toward the neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Partial remainder and dividend/quotient word of one division lane
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] word;
  } step_t;

  // One divider pipeline stage: both lanes plus the pixel side data
  typedef struct packed {
    step_t      sat;
    step_t      hue;
    logic [7:0] value;
    logic [7:0] chroma;
    logic       neg;
    logic [7:0] offset;
  } div_t;

  // One restoring-division step: shift in the next dividend bit, try subtract
  function automatic step_t div_step(step_t s, logic [7:0] divisor);
    logic [8:0] trial;
    step_t      r;
    trial = {s.rem, s.word[7]};
    if (trial >= {1'b0, divisor}) begin
      r.rem  = 8'(trial - {1'b0, divisor});
      r.word = {s.word[6:0], 1'b1};
    end else begin
      r.rem  = trial[7:0];
      r.word = {s.word[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== design/rthi_if.sv =====
// Valid/ready channel interfaces for RGB pixels and HSV results.
interface rthi_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthi_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// ===== design/rgb_to_hsv_integer_top.sv =====
// Top level of the 8-bit integer RGB to HSV converter.
//
// Channels: rgb_i takes one RGB pixel per transaction (valid/ready),
// hsv_o gives one HSV result per pixel, in input order.
// Throughput: one pixel per clock, sustained, while hsv_o is ready.
// Path from an input transaction to the result: the queue entry, stage 0
// (dividends scaled from the queue head and registered), eight divider
// stages at one quotient bit each, and the output register.
// A four-entry queue sits between the classifier and the divider pipeline.
// When the receiver stalls, the whole divider pipeline holds; the queue
// keeps taking pixels until it is full, then rgb_i.ready drops.
// Reset (rst_ni, asynchronous, active low) empties the queue and clears
// every stage valid; no result is pending after reset. No configuration.
module rgb_to_hsv_integer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rthi_rgb_if.sink   rgb_i,
  rthi_hsv_if.source hsv_o
);

  rthi_pkg::cls_t       cls_in;
  rthi_pkg::cls_t       cls_out;
  rthi_pkg::fifo_stat_t fifo_stat;
  logic                 push;
  logic                 pop;

  rthi_front u_front (
    .rgb_i  (rgb_i),
    .full_i (fifo_stat.full),
    .push_o (push),
    .cls_o  (cls_in)
  );

  rthi_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls_in),
    .pop_i  (pop),
    .data_o (cls_out),
    .stat_o (fifo_stat)
  );

  rthi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cls_i   (cls_out),
    .avail_i (!fifo_stat.empty),
    .pop_o   (pop),
    .hsv_o   (hsv_o)
  );

`ifndef SYNTHESIS
  // Gray pixels carry no hue
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.saturation == 8'd0 |-> hsv_o.hue == 8'd0)
    else $error("nonzero hue with zero saturation");

  // Black pixels give all-zero results
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.value == 8'd0 |-> hsv_o.saturation == 8'd0)
    else $error("nonzero saturation with zero value");

  // Queue only fills through input transactions
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rgb_i.ready) |-> $past(rgb_i.valid))
    else $error("input ready dropped without a transaction");
`endif

endmodule

// ===== design/rthi_front.sv =====
// Front end: accepts RGB pixels, finds max/min and the hue sector.
module rthi_front (
  rthi_rgb_if.sink       rgb_i,
  input  logic           full_i,
  output logic           push_o,
  output rthi_pkg::cls_t cls_o
);

  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] p;
  logic [7:0] q;

  // Accept whenever the queue has room
  assign rgb_i.ready = !full_i;
  assign push_o      = rgb_i.valid && !full_i;

  // Max and min of the three channels
  always_comb begin
    mx = (rgb_i.red > rgb_i.green) ? rgb_i.red : rgb_i.green;
    if (rgb_i.blue > mx) mx = rgb_i.blue;
    mn = (rgb_i.red < rgb_i.green) ? rgb_i.red : rgb_i.green;
    if (rgb_i.blue < mn) mn = rgb_i.blue;
  end

  // Sector select: ties go to red, then green
  always_comb begin
    priority if (mx == rgb_i.red) begin
      p            = rgb_i.green;
      q            = rgb_i.blue;
      cls_o.offset = rthi_pkg::HueRed;
    end else if (mx == rgb_i.green) begin
      p            = rgb_i.blue;
      q            = rgb_i.red;
      cls_o.offset = rthi_pkg::HueGreen;
    end else begin
      p            = rgb_i.red;
      q            = rgb_i.green;
      cls_o.offset = rthi_pkg::HueBlue;
    end
    cls_o.value  = mx;
    cls_o.chroma = mx - mn;
    cls_o.neg    = p < q;
    cls_o.dmag   = (p < q) ? (q - p) : (p - q);
  end

endmodule

// ===== design/rthi_fifo.sv =====
// Short queue of classified pixels between front end and divider.
module rthi_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rthi_pkg::cls_t       data_i,
  input  logic                 pop_i,
  output rthi_pkg::cls_t       data_o,
  output rthi_pkg::fifo_stat_t stat_o
);

  localparam logic [rthi_pkg::FifoPtrW:0] CntFull = (rthi_pkg::FifoPtrW + 1)'(rthi_pkg::FifoDepth);

  rthi_pkg::cls_t                mem_q [rthi_pkg::FifoDepth];
  logic [rthi_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [rthi_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [rthi_pkg::FifoPtrW:0]   cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== design/rthi_back.sv =====
// Back end: pipelined dividers for saturation and hue, output register.
module rthi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rthi_pkg::cls_t cls_i,
  input  logic           avail_i,
  output logic           pop_o,
  rthi_hsv_if.source     hsv_o
);

  localparam int N = rthi_pkg::DivSteps;

  rthi_pkg::div_t pipe_q [N+1];
  rthi_pkg::div_t step_d [1:N];
  rthi_pkg::div_t load_d;
  logic [N:0]     vld_q;
  logic           out_vld_q;
  logic [7:0]     hue_q, sat_q, val_q;
  logic [7:0]     hue_d, sat_d;
  logic           adv;
  logic [15:0]    sat_dvd;
  logic [15:0]    hue_dvd;

  // Whole pipeline moves unless the output holds a stalled result
  assign adv   = !out_vld_q || hsv_o.ready;
  assign pop_o = adv && avail_i;

  // Stage 0: constant-scaled dividends
  always_comb begin
    sat_dvd         = {8'd0, cls_i.chroma} * {8'd0, rthi_pkg::FullScale};
    hue_dvd         = {8'd0, cls_i.dmag} * {8'd0, rthi_pkg::HueStep};
    load_d.sat.rem  = sat_dvd[15:8];
    load_d.sat.word = sat_dvd[7:0];
    load_d.hue.rem  = hue_dvd[15:8];
    load_d.hue.word = hue_dvd[7:0];
    load_d.value    = cls_i.value;
    load_d.chroma   = cls_i.chroma;
    load_d.neg      = cls_i.neg;
    load_d.offset   = cls_i.offset;
  end

  // Valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[N-1:0], avail_i};
      out_vld_q <= vld_q[N];
    end
  end

  // Divider steps: each stage adds one quotient bit to both lanes
  always_comb begin
    for (int k = 1; k <= N; k++) begin
      step_d[k]     = pipe_q[k-1];
      step_d[k].sat = rthi_pkg::div_step(pipe_q[k-1].sat, pipe_q[k-1].value);
      step_d[k].hue = rthi_pkg::div_step(pipe_q[k-1].hue, pipe_q[k-1].chroma);
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= load_d;
      for (int k = 1; k <= N; k++) pipe_q[k] <= step_d[k];
    end
  end

  // Final hue is offset plus or minus the quotient, saturation the quotient; gray or black gives zero
  always_comb begin
    if (pipe_q[N].chroma == '0) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = pipe_q[N].neg ? pipe_q[N].offset - pipe_q[N].hue.word
                            : pipe_q[N].offset + pipe_q[N].hue.word;
      sat_d = pipe_q[N].sat.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= pipe_q[N].value;
    end
  end

  assign hsv_o.valid      = out_vld_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = val_q;

endmodule

// ===== tb/rgb_to_hsv_integer_checker.sv =====
// Checker for the RGB to HSV converter: predicts each result and compares it at the output.
module rgb_to_hsv_integer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pix_valid_i,
  input  logic       pix_ready_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  logic [7:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] value_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
  } hsv_t;

  hsv_t expected_hsv_q[$];
  int   mismatches = 0;
  int   checked    = 0;
  int   pending    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign checked_o    = checked;

  // HSV of one pixel: value = max, saturation = 255*chroma/max, hue by sector
  function automatic hsv_t hsv_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  chroma;
    logic [7:0]  dmag;
    logic [7:0]  offset;
    logic        neg;
    logic [15:0] sat_q;
    logic [15:0] mag;
    hsv_t        res;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    chroma = mx - mn;
    res = '0;
    res.value = mx;
    // black pixel keeps hue and saturation at zero
    if (mx != 8'd0) begin
      sat_q = (16'(rthi_pkg::FullScale) * 16'(chroma)) / 16'(mx);
      res.saturation = sat_q[7:0];
      // gray pixel keeps hue at zero
      if (sat_q != 16'd0) begin
        // ties go to red, then green
        if (mx == r) begin
          offset = rthi_pkg::HueRed;
          neg    = g < b;
          dmag   = neg ? b - g : g - b;
        end else if (mx == g) begin
          offset = rthi_pkg::HueGreen;
          neg    = b < r;
          dmag   = neg ? r - b : b - r;
        end else begin
          offset = rthi_pkg::HueBlue;
          neg    = r < g;
          dmag   = neg ? g - r : r - g;
        end
        // quotient truncates toward zero, the sum wraps modulo 256
        mag = (16'(rthi_pkg::HueStep) * 16'(dmag)) / 16'(chroma);
        res.hue = neg ? offset - mag[7:0] : offset + mag[7:0];
      end
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what, hsv_t want, hsv_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d", $time, what,
               want.hue, want.saturation, want.value, got.hue, got.saturation, got.value);
  endfunction

  // Output transactions are checked first, then the accepted pixel is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch
    hsv_t got;
    hsv_t want;
    if (!rst_ni) begin
      expected_hsv_q.delete();
      pending = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = '{hue: hue_i, saturation: saturation_i, value: value_i};
        if (expected_hsv_q.size() == 0) begin
          report_mismatch("result with no pixel pending", '0, got);
        end else begin
          want = expected_hsv_q.pop_front();
          checked++;
          if (got.hue != want.hue)               report_mismatch("hue", want, got);
          if (got.saturation != want.saturation) report_mismatch("saturation", want, got);
          if (got.value != want.value)           report_mismatch("value", want, got);
        end
      end
      if (pix_valid_i && pix_ready_i)
        expected_hsv_q.push_back(hsv_of_pixel(red_i, green_i, blue_i));
      pending = expected_hsv_q.size();
    end
  end

endmodule

// ===== tb/rgb_to_hsv_integer_top_tb.sv =====
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
module rgb_to_hsv_integer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 200000;
  localparam int PhaseCount    = 4;
  localparam int PixelsPerPhase = 456;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 30;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rthi_rgb_if rgb ();
  rthi_hsv_if hsv ();

  int fail_count;
  int pending;
  int checked;
  int pixels_sent     = 0;
  int src_idle_pct    = 0;
  int sink_stall_pct  = 0;
  int hold_left       = 0;
  bit hold_req        = 1'b0;
  int cycle_count     = 0;

  always #5 clk_i = ~clk_i;

  rgb_to_hsv_integer_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rgb_i (rgb),
    .hsv_o (hsv)
  );

  rgb_to_hsv_integer_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (rgb.valid),
    .pix_ready_i (rgb.ready),
    .red_i       (rgb.red),
    .green_i     (rgb.green),
    .blue_i      (rgb.blue),
    .res_valid_i (hsv.valid),
    .res_ready_i (hsv.ready),
    .hue_i       (hsv.hue),
    .saturation_i(hsv.saturation),
    .value_i     (hsv.value),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Receiver: random stall, or a long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hsv.ready = 1'b0;
      hold_left--;
    end else begin
      hsv.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offer one pixel, after a random idle gap, and wait for its transaction
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      rgb.valid = 1'b0;
      rgb.red   = 8'($urandom);
      rgb.green = 8'($urandom);
      rgb.blue  = 8'($urandom);
      @(posedge clk_i);
    end
    @(negedge clk_i);
    rgb.valid = 1'b1;
    rgb.red   = r;
    rgb.green = g;
    rgb.blue  = b;
    do @(posedge clk_i); while (!rgb.ready);
    pixels_sent++;
  endtask

  // Random pixel, biased toward gray, tied, extreme and low-chroma colors
  task automatic send_random_pixel();
    logic [7:0] ch[3];
    logic [7:0] top;
    logic [7:0] base;
    int         kind;
    int         pick;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) ch[i] = 8'($urandom);
    case (kind)
      4: begin
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      5: begin
        top  = 8'($urandom_range(1, 255));
        pick = $urandom_range(2);
        for (int i = 0; i < 3; i++)
          ch[i] = (i == pick) ? 8'($urandom_range(0, top - 1)) : top;
      end
      6: begin
        for (int i = 0; i < 3; i++) begin
          pick = $urandom_range(2);
          ch[i] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(3));
      end
      8: begin
        base = 8'($urandom_range(254));
        for (int i = 0; i < 3; i++) ch[i] = base + 8'($urandom_range(1));
      end
      9: begin
        ch[$urandom_range(2)] = 8'd255;
      end
      default: ;
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  // Run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results pending", cycle_count, pending);
    $display("[rgb_to_hsv_integer_top] ERROR");
    $finish;
  end

  initial begin
    int src_pct[PhaseCount];
    int sink_pct[PhaseCount];
    src_pct  = '{0, 46, 0, 17};
    sink_pct = '{0, 0, 46, 17};
    rgb.valid = 1'b0;
    rgb.red   = '0;
    rgb.green = '0;
    rgb.blue  = '0;
    hsv.ready = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: black, white, gray, primaries, ties, wrapped hue, minimal chroma
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd10);
    send_pixel(8'd200, 8'd0,   8'd200);
    send_pixel(8'd100, 8'd200, 8'd0);
    send_pixel(8'd0,   8'd50,  8'd200);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd1);
    send_pixel(8'd170, 8'd85,  8'd51);
    send_pixel(8'd85,  8'd170, 8'd204);
    send_pixel(8'd254, 8'd253, 8'd255);

    // Random phases; the first opens with a long output hold to fill the pipeline
    for (int p = 0; p < PhaseCount; p++) begin
      src_idle_pct   = src_pct[p];
      sink_stall_pct = sink_pct[p];
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < PixelsPerPhase; n++) send_random_pixel();
    end
    @(negedge clk_i);
    rgb.valid = 1'b0;

    // Drain, then keep the clock running so that any extra result is caught
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d pixels, checked %0d results, in four sender/receiver idle mixes",
             pixels_sent, checked);
    $display("plus a %0d-cycle output hold; black, gray, tied and wrapped-hue pixels included",
             HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("[rgb_to_hsv_integer_top] OK");
    end else begin
      $display("%0d mismatches, %0d results pending", fail_count, pending);
      $display("[rgb_to_hsv_integer_top] ERROR");
    end
    $finish;
  end

endmodule
